// ----- rtl/core/acw_pkg.sv -----
// shared constants for the aspect crop window block
`timescale 1ns / 1ps

package acw_pkg;

    // width of every coordinate field on the stream buses
    localparam int FIELD_W = 16;

    // padding fraction register, unsigned Q2.8
    localparam int PAD_W         = 10;
    localparam int PAD_FRAC_BITS = 8;
    localparam int PAD_MIN       = 8;

    // height from width: (9*w + 8) >> 4
    localparam int HEIGHT_MUL   = 9;
    localparam int HEIGHT_RND   = 8;
    localparam int HEIGHT_SHIFT = 4;

    // width from height: floor((32*h + 9) / 18) == floor((16*h + 4) / 9)
    localparam int WIDTH_SHIFT = 4;
    localparam int WIDTH_RND   = 4;
    localparam int WIDTH_DIV   = 9;

    // stream bus widths
    localparam int S_TDATA_W = 6 * FIELD_W;
    localparam int M_TDATA_W = 4 * FIELD_W;

endpackage

// ----- rtl/core/acw_prep.sv -----
// size fallback, padding products and the padded, clamped box
`timescale 1ns / 1ps

module acw_prep #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [acw_pkg::PAD_W-1:0]   pad_fraction,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_present,
    input  logic [COORD_BITS-1:0]       in_bx,
    input  logic [COORD_BITS-1:0]       in_by,
    input  logic [COORD_BITS-1:0]       in_bw,
    input  logic [COORD_BITS-1:0]       in_bh,
    input  logic [COORD_BITS-1:0]       in_iw,
    input  logic [COORD_BITS-1:0]       in_ih,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [6*COORD_BITS:0]       out_geom,
    output logic [COORD_BITS-1:0]       out_x0,
    output logic [COORD_BITS-1:0]       out_y0,
    output logic [COORD_BITS-1:0]       out_x1,
    output logic [COORD_BITS-1:0]       out_y1
);

    localparam int C  = COORD_BITS;
    localparam int PW = COORD_BITS + acw_pkg::PAD_W;

    typedef struct packed {
        logic         ok;
        logic [C-1:0] bx;
        logic [C-1:0] by;
        logic [C-1:0] bw;
        logic [C-1:0] bh;
        logic [C-1:0] iw;
        logic [C-1:0] ih;
    } geom_t;

    // stage 1: fallback sizes and pad products
    logic [C:0]    far_x;
    logic [C:0]    far_y;
    geom_t         g1_next;
    logic [PW-1:0] prod_x_next;
    logic [PW-1:0] prod_y_next;

    logic          s1_v_reg;
    geom_t         s1_geom_reg;
    logic [PW-1:0] s1_prod_x_reg;
    logic [PW-1:0] s1_prod_y_reg;
    logic          s1_ready;

    // stage 2: padded box
    logic [C+2:0]  pad_x;
    logic [C+2:0]  pad_y;
    logic [C+3:0]  x1_ext;
    logic [C+3:0]  y1_ext;
    logic [C-1:0]  x0_next;
    logic [C-1:0]  y0_next;
    logic [C-1:0]  x1_next;
    logic [C-1:0]  y1_next;

    logic          s2_v_reg;
    geom_t         s2_geom_reg;
    logic [C-1:0]  s2_x0_reg;
    logic [C-1:0]  s2_y0_reg;
    logic [C-1:0]  s2_x1_reg;
    logic [C-1:0]  s2_y1_reg;
    logic          s2_ready;

    assign far_x = (C+1)'(in_bx) + (C+1)'(in_bw);
    assign far_y = (C+1)'(in_by) + (C+1)'(in_bh);

    always_comb
    begin
        g1_next.bx = in_bx;
        g1_next.by = in_by;
        g1_next.bw = in_bw;
        g1_next.bh = in_bh;
        // unknown size falls back to the far edge, saturated
        if (in_iw != '0)
            g1_next.iw = in_iw;
        else if (far_x[C])
            g1_next.iw = '1;
        else
            g1_next.iw = far_x[C-1:0];
        if (in_ih != '0)
            g1_next.ih = in_ih;
        else if (far_y[C])
            g1_next.ih = '1;
        else
            g1_next.ih = far_y[C-1:0];
        g1_next.ok = in_present && (g1_next.iw != '0) && (g1_next.ih != '0);
    end

    assign prod_x_next = PW'(in_bw) * PW'(pad_fraction);
    assign prod_y_next = PW'(in_bh) * PW'(pad_fraction);

    assign s2_ready = !s2_v_reg || out_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_v_reg <= in_valid;
            if (s2_ready)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_geom_reg   <= g1_next;
            s1_prod_x_reg <= prod_x_next;
            s1_prod_y_reg <= prod_y_next;
        end
    end

    // padding per side: (size * fraction >> 8) + 8
    assign pad_x = (C+3)'(s1_prod_x_reg >> acw_pkg::PAD_FRAC_BITS)
                 + (C+3)'(acw_pkg::PAD_MIN);
    assign pad_y = (C+3)'(s1_prod_y_reg >> acw_pkg::PAD_FRAC_BITS)
                 + (C+3)'(acw_pkg::PAD_MIN);

    assign x1_ext = (C+4)'(s1_geom_reg.bx) + (C+4)'(s1_geom_reg.bw) + (C+4)'(pad_x);
    assign y1_ext = (C+4)'(s1_geom_reg.by) + (C+4)'(s1_geom_reg.bh) + (C+4)'(pad_y);

    always_comb
    begin
        if ((C+3)'(s1_geom_reg.bx) > pad_x)
            x0_next = C'((C+3)'(s1_geom_reg.bx) - pad_x);
        else
            x0_next = '0;
        if ((C+3)'(s1_geom_reg.by) > pad_y)
            y0_next = C'((C+3)'(s1_geom_reg.by) - pad_y);
        else
            y0_next = '0;
        if (x1_ext > (C+4)'(s1_geom_reg.iw))
            x1_next = s1_geom_reg.iw;
        else
            x1_next = C'(x1_ext);
        if (y1_ext > (C+4)'(s1_geom_reg.ih))
            y1_next = s1_geom_reg.ih;
        else
            y1_next = C'(y1_ext);
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s2_ready)
        begin
            s2_geom_reg <= s1_geom_reg;
            s2_x0_reg   <= x0_next;
            s2_y0_reg   <= y0_next;
            s2_x1_reg   <= x1_next;
            s2_y1_reg   <= y1_next;
        end
    end

    assign out_valid = s2_v_reg;
    assign out_geom  = s2_geom_reg;
    assign out_x0    = s2_x0_reg;
    assign out_y0    = s2_y0_reg;
    assign out_x1    = s2_x1_reg;
    assign out_y1    = s2_y1_reg;

endmodule

// ----- rtl/core/acw_fit.sv -----
// 16:9 widening and shrink-to-image of the padded box
`timescale 1ns / 1ps

module acw_fit #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [6*COORD_BITS:0] in_geom,
    input  logic [COORD_BITS-1:0] in_x0,
    input  logic [COORD_BITS-1:0] in_y0,
    input  logic [COORD_BITS-1:0] in_x1,
    input  logic [COORD_BITS-1:0] in_y1,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [6*COORD_BITS:0] out_geom,
    output logic [COORD_BITS-1:0] out_x0,
    output logic [COORD_BITS-1:0] out_y0,
    output logic [COORD_BITS-1:0] out_x1,
    output logic [COORD_BITS-1:0] out_y1,
    output logic [COORD_BITS-1:0] out_cw,
    output logic [COORD_BITS-1:0] out_ch
);

    localparam int C = COORD_BITS;
    localparam int M = COORD_BITS + acw_pkg::WIDTH_SHIFT;
    localparam int NS = 4;

    typedef struct packed {
        logic         ok;
        logic [C-1:0] bx;
        logic [C-1:0] by;
        logic [C-1:0] bw;
        logic [C-1:0] bh;
        logic [C-1:0] iw;
        logic [C-1:0] ih;
    } geom_t;

    typedef struct packed {
        geom_t        geom;
        logic [C-1:0] x0;
        logic [C-1:0] y0;
        logic [C-1:0] x1;
        logic [C-1:0] y1;
    } box_t;

    // (9*v + 8) >> 4
    function automatic logic [C-1:0] height_of(input logic [C-1:0] v);
        logic [C+3:0] t;
        t = (C+4)'(v) * (C+4)'(acw_pkg::HEIGHT_MUL) + (C+4)'(acw_pkg::HEIGHT_RND);
        return t[C+3:acw_pkg::HEIGHT_SHIFT];
    endfunction

    // 16*h + 4, the numerator of the width division
    function automatic logic [M-1:0] width_num(input logic [C-1:0] h);
        return (M'(h) << acw_pkg::WIDTH_SHIFT) + M'(acw_pkg::WIDTH_RND);
    endfunction

    // x/9 estimate by the 8/9 series; div9_fix moves it down by one or up by up to two
    function automatic logic [M-1:0] div9_est(input logic [M-1:0] x);
        logic [M-1:0] q;
        q = x - (x >> 3);
        q = q + (q >> 6);
        q = q + (q >> 12);
        q = q + (q >> 24);
        return q >> 3;
    endfunction

    function automatic logic [M-1:0] div9_fix(input logic [M-1:0] x,
                                               input logic [M-1:0] q);
        logic signed [M+1:0] r;
        r = $signed((M+2)'(x)) - $signed((M+2)'(q) * (M+2)'(acw_pkg::WIDTH_DIV));
        if (r < 0)
            return q - M'(1);
        else if (r >= $signed((M+2)'(2 * acw_pkg::WIDTH_DIV)))
            return q + M'(2);
        else if (r >= $signed((M+2)'(acw_pkg::WIDTH_DIV)))
            return q + M'(1);
        else
            return q;
    endfunction

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    box_t          in_box;
    box_t          s1_box_reg;
    box_t          s2_box_reg;
    box_t          s3_box_reg;
    box_t          s4_box_reg;

    // stage 1: padded size
    logic [C-1:0]  pw_next;
    logic [C-1:0]  ph_next;
    logic [C-1:0]  s1_pw_reg;
    logic [C-1:0]  s1_ph_reg;

    // stage 2: aspect test, heights, division estimates
    logic [C+3:0]  nine_w;
    logic [C+3:0]  sixteen_h;
    logic          s2_wide_reg;
    logic [C-1:0]  s2_pw_reg;
    logic [C-1:0]  s2_ph_reg;
    logic [C-1:0]  s2_hpw_reg;
    logic [C-1:0]  s2_hiw_reg;
    logic [M-1:0]  s2_qph_reg;
    logic [M-1:0]  s2_qih_reg;

    // stage 3: corrected widths
    logic [M-1:0]  wph_full;
    logic [M-1:0]  wih_full;
    logic          s3_wide_reg;
    logic [C-1:0]  s3_pw_reg;
    logic [C-1:0]  s3_ph_reg;
    logic [C-1:0]  s3_hpw_reg;
    logic [C-1:0]  s3_hiw_reg;
    logic [C:0]    s3_wph_reg;
    logic [C:0]    s3_wih_reg;

    // stage 4: chosen window size
    logic [C:0]    cw0;
    logic [C:0]    cw1;
    logic [C:0]    cw2;
    logic [C-1:0]  ch0;
    logic [C-1:0]  ch1;
    logic [C-1:0]  ch2;
    logic [C-1:0]  cw_next;
    logic [C-1:0]  ch_next;
    logic [C-1:0]  s4_cw_reg;
    logic [C-1:0]  s4_ch_reg;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign in_box.geom = in_geom;
    assign in_box.x0   = in_x0;
    assign in_box.y0   = in_y0;
    assign in_box.x1   = in_x1;
    assign in_box.y1   = in_y1;

    // empty or inverted box counts as one pixel
    assign pw_next = (in_x1 > in_x0) ? (in_x1 - in_x0) : C'(1);
    assign ph_next = (in_y1 > in_y0) ? (in_y1 - in_y0) : C'(1);

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy[0])
        begin
            s1_box_reg <= in_box;
            s1_pw_reg  <= pw_next;
            s1_ph_reg  <= ph_next;
        end
    end

    assign nine_w    = (C+4)'(s1_pw_reg) * (C+4)'(acw_pkg::HEIGHT_MUL);
    assign sixteen_h = (C+4)'(s1_ph_reg) << acw_pkg::HEIGHT_SHIFT;

    always_ff @(posedge clk)
    begin
        if (v_reg[0] && rdy[1])
        begin
            s2_box_reg  <= s1_box_reg;
            s2_wide_reg <= nine_w > sixteen_h;
            s2_pw_reg   <= s1_pw_reg;
            s2_ph_reg   <= s1_ph_reg;
            s2_hpw_reg  <= height_of(s1_pw_reg);
            s2_hiw_reg  <= height_of(s1_box_reg.geom.iw);
            s2_qph_reg  <= div9_est(width_num(s1_ph_reg));
            s2_qih_reg  <= div9_est(width_num(s1_box_reg.geom.ih));
        end
    end

    assign wph_full = div9_fix(width_num(s2_ph_reg), s2_qph_reg);
    assign wih_full = div9_fix(width_num(s2_box_reg.geom.ih), s2_qih_reg);

    always_ff @(posedge clk)
    begin
        if (v_reg[1] && rdy[2])
        begin
            s3_box_reg  <= s2_box_reg;
            s3_wide_reg <= s2_wide_reg;
            s3_pw_reg   <= s2_pw_reg;
            s3_ph_reg   <= s2_ph_reg;
            s3_hpw_reg  <= s2_hpw_reg;
            s3_hiw_reg  <= s2_hiw_reg;
            s3_wph_reg  <= wph_full[C:0];
            s3_wih_reg  <= wih_full[C:0];
        end
    end

    always_comb
    begin
        // widen to 16:9
        if (s3_wide_reg)
        begin
            cw0 = (C+1)'(s3_pw_reg);
            ch0 = s3_hpw_reg;
        end
        else
        begin
            cw0 = s3_wph_reg;
            ch0 = s3_ph_reg;
        end
        // too wide for the image
        if (cw0 > (C+1)'(s3_box_reg.geom.iw))
        begin
            cw1 = (C+1)'(s3_box_reg.geom.iw);
            ch1 = s3_hiw_reg;
        end
        else
        begin
            cw1 = cw0;
            ch1 = ch0;
        end
        // too tall for the image
        if (ch1 > s3_box_reg.geom.ih)
        begin
            cw2 = s3_wih_reg;
            ch2 = s3_box_reg.geom.ih;
        end
        else
        begin
            cw2 = cw1;
            ch2 = ch1;
        end
        cw_next = (cw2 > (C+1)'(s3_box_reg.geom.iw)) ? s3_box_reg.geom.iw : cw2[C-1:0];
        ch_next = (ch2 > s3_box_reg.geom.ih) ? s3_box_reg.geom.ih : ch2;
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[2] && rdy[3])
        begin
            s4_box_reg <= s3_box_reg;
            s4_cw_reg  <= cw_next;
            s4_ch_reg  <= ch_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_geom  = s4_box_reg.geom;
    assign out_x0    = s4_box_reg.x0;
    assign out_y0    = s4_box_reg.y0;
    assign out_x1    = s4_box_reg.x1;
    assign out_y1    = s4_box_reg.y1;
    assign out_cw    = s4_cw_reg;
    assign out_ch    = s4_ch_reg;

endmodule

// ----- rtl/core/acw_place.sv -----
// window placement: centre on the box, cover the padded box, clamp
`timescale 1ns / 1ps

module acw_place #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [6*COORD_BITS:0] in_geom,
    input  logic [COORD_BITS-1:0] in_x0,
    input  logic [COORD_BITS-1:0] in_y0,
    input  logic [COORD_BITS-1:0] in_x1,
    input  logic [COORD_BITS-1:0] in_y1,
    input  logic [COORD_BITS-1:0] in_cw,
    input  logic [COORD_BITS-1:0] in_ch,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_ok,
    output logic [COORD_BITS-1:0] out_cx,
    output logic [COORD_BITS-1:0] out_cy,
    output logic [COORD_BITS-1:0] out_cw,
    output logic [COORD_BITS-1:0] out_ch
);

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic         ok;
        logic [C-1:0] bx;
        logic [C-1:0] by;
        logic [C-1:0] bw;
        logic [C-1:0] bh;
        logic [C-1:0] iw;
        logic [C-1:0] ih;
    } geom_t;

    function automatic logic [C-1:0] clamp_pos(input logic signed [C+2:0] v,
                                                input logic [C-1:0]        hi);
        if (v < 0)
            return '0;
        else if (v > $signed((C+3)'(hi)))
            return hi;
        else
            return v[C-1:0];
    endfunction

    geom_t               g_in;

    // stage 1: centred position
    logic signed [C+2:0] ctr_x;
    logic signed [C+2:0] ctr_y;
    logic [C-1:0]        lim_x_in;
    logic [C-1:0]        lim_y_in;

    logic                s1_v_reg;
    logic                s1_ready;
    logic                s1_ok_reg;
    logic [C-1:0]        s1_lim_x_reg;
    logic [C-1:0]        s1_lim_y_reg;
    logic [C-1:0]        s1_x0_reg;
    logic [C-1:0]        s1_y0_reg;
    logic [C-1:0]        s1_x1_reg;
    logic [C-1:0]        s1_y1_reg;
    logic [C-1:0]        s1_cw_reg;
    logic [C-1:0]        s1_ch_reg;
    logic [C-1:0]        s1_cx_reg;
    logic [C-1:0]        s1_cy_reg;

    // stage 2: cover and clamp
    logic [C-1:0]        cx_left;
    logic [C-1:0]        cy_top;
    logic signed [C+2:0] cx_cover;
    logic signed [C+2:0] cy_cover;
    logic                ok_next;

    logic                s2_v_reg;
    logic                s2_ready;
    logic                s2_ok_reg;
    logic [C-1:0]        s2_cx_reg;
    logic [C-1:0]        s2_cy_reg;
    logic [C-1:0]        s2_cw_reg;
    logic [C-1:0]        s2_ch_reg;

    assign g_in = in_geom;

    assign ctr_x = $signed((C+3)'(g_in.bx) + (C+3)'(g_in.bw >> 1) - (C+3)'(in_cw >> 1));
    assign ctr_y = $signed((C+3)'(g_in.by) + (C+3)'(g_in.bh >> 1) - (C+3)'(in_ch >> 1));
    assign lim_x_in = g_in.iw - in_cw;
    assign lim_y_in = g_in.ih - in_ch;

    assign s2_ready = !s2_v_reg || out_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_v_reg <= in_valid;
            if (s2_ready)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_ok_reg    <= g_in.ok;
            s1_lim_x_reg <= lim_x_in;
            s1_lim_y_reg <= lim_y_in;
            s1_x0_reg    <= in_x0;
            s1_y0_reg    <= in_y0;
            s1_x1_reg    <= in_x1;
            s1_y1_reg    <= in_y1;
            s1_cw_reg    <= in_cw;
            s1_ch_reg    <= in_ch;
            s1_cx_reg    <= clamp_pos(ctr_x, lim_x_in);
            s1_cy_reg    <= clamp_pos(ctr_y, lim_y_in);
        end
    end

    always_comb
    begin
        cx_left = (s1_x0_reg < s1_cx_reg) ? s1_x0_reg : s1_cx_reg;
        cy_top  = (s1_y0_reg < s1_cy_reg) ? s1_y0_reg : s1_cy_reg;
        if ((C+1)'(s1_x1_reg) > (C+1)'(cx_left) + (C+1)'(s1_cw_reg))
            cx_cover = $signed((C+3)'(s1_x1_reg) - (C+3)'(s1_cw_reg));
        else
            cx_cover = $signed((C+3)'(cx_left));
        if ((C+1)'(s1_y1_reg) > (C+1)'(cy_top) + (C+1)'(s1_ch_reg))
            cy_cover = $signed((C+3)'(s1_y1_reg) - (C+3)'(s1_ch_reg));
        else
            cy_cover = $signed((C+3)'(cy_top));
        ok_next = s1_ok_reg && (s1_cw_reg != '0) && (s1_ch_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s2_ready)
        begin
            s2_ok_reg <= ok_next;
            s2_cx_reg <= ok_next ? clamp_pos(cx_cover, s1_lim_x_reg) : '0;
            s2_cy_reg <= ok_next ? clamp_pos(cy_cover, s1_lim_y_reg) : '0;
            s2_cw_reg <= ok_next ? s1_cw_reg : '0;
            s2_ch_reg <= ok_next ? s1_ch_reg : '0;
        end
    end

    assign out_valid = s2_v_reg;
    assign out_ok    = s2_ok_reg;
    assign out_cx    = s2_cx_reg;
    assign out_cy    = s2_cy_reg;
    assign out_cw    = s2_cw_reg;
    assign out_ch    = s2_ch_reg;

endmodule

// ----- rtl/core/aspect_crop_window.sv -----
// top level of the 16:9 crop window block
`timescale 1ns / 1ps

// aspect_crop_window: turns one region box and the image size into a 16:9
// crop window around it.
//   s_axis: one beat per box. tdata holds box_x, box_y, box_w, box_h,
//     image_w_in, image_h_in (16 bits each, from bit 0 up); tuser is
//     region_present. an image size of 0 falls back to the box's far edge.
//   m_axis: one beat per box, in order. tdata holds crop_x, crop_y, crop_w,
//     crop_h; tuser is crop_ok. when crop_ok is low the window fields are 0.
//   pad_fraction_we / pad_fraction_wdata: writes the unsigned Q2.8 padding
//     fraction; write it only while no box is in flight.
// throughput: one box per cycle while m_axis accepts beats; every stage
//   is a short piece of logic behind its own register (input register,
//   8 working stages, output register), and the only multipliers with
//   two variable operands are the 16x10 padding products.
// reset clears all stage valids and sets pad_fraction to 0.
// when m_axis stalls, each stage holds while its successor is full; empty
//   stages keep filling, so s_axis_tready drops only once the pipe is full.
module aspect_crop_window #(
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pad_fraction_we,
    input  logic [acw_pkg::PAD_W-1:0]       pad_fraction_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // box_x, box_y, box_w, box_h, image_w_in, image_h_in
    input  logic [acw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // region_present
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // crop_x, crop_y, crop_w, crop_h
    output logic [acw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // crop_ok
    output logic                            m_axis_tuser
);

    localparam int C  = COORD_BITS;
    localparam int FW = acw_pkg::FIELD_W;

    // padding fraction register
    logic [acw_pkg::PAD_W-1:0] pad_fraction_reg;

    // input register, coordinates masked to the coordinate width
    logic          in_v_reg;
    logic          in_present_reg;
    logic [C-1:0]  in_bx_reg;
    logic [C-1:0]  in_by_reg;
    logic [C-1:0]  in_bw_reg;
    logic [C-1:0]  in_bh_reg;
    logic [C-1:0]  in_iw_reg;
    logic [C-1:0]  in_ih_reg;
    logic          in_stage_ready;

    // prep -> fit
    logic          prep_in_ready;
    logic          prep_valid;
    logic          prep_ready;
    logic [6*C:0]  prep_geom;
    logic [C-1:0]  prep_x0;
    logic [C-1:0]  prep_y0;
    logic [C-1:0]  prep_x1;
    logic [C-1:0]  prep_y1;

    // fit -> place
    logic          fit_valid;
    logic          fit_ready;
    logic [6*C:0]  fit_geom;
    logic [C-1:0]  fit_x0;
    logic [C-1:0]  fit_y0;
    logic [C-1:0]  fit_x1;
    logic [C-1:0]  fit_y1;
    logic [C-1:0]  fit_cw;
    logic [C-1:0]  fit_ch;

    // place -> output register
    logic          place_valid;
    logic          place_ready;
    logic          place_ok;
    logic [C-1:0]  place_cx;
    logic [C-1:0]  place_cy;
    logic [C-1:0]  place_cw;
    logic [C-1:0]  place_ch;

    // output register
    logic          out_v_reg;
    logic          out_ok_reg;
    logic [FW-1:0] out_cx_reg;
    logic [FW-1:0] out_cy_reg;
    logic [FW-1:0] out_cw_reg;
    logic [FW-1:0] out_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_fraction_reg <= '0;
        else if (pad_fraction_we)
            pad_fraction_reg <= pad_fraction_wdata;
    end

    // input register takes a beat whenever it is empty or draining
    assign in_stage_ready = !in_v_reg || prep_in_ready;
    assign s_axis_tready  = in_stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_stage_ready)
            in_v_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_stage_ready)
        begin
            in_present_reg <= s_axis_tuser;
            in_bx_reg      <= C'(s_axis_tdata[0*FW +: FW]);
            in_by_reg      <= C'(s_axis_tdata[1*FW +: FW]);
            in_bw_reg      <= C'(s_axis_tdata[2*FW +: FW]);
            in_bh_reg      <= C'(s_axis_tdata[3*FW +: FW]);
            in_iw_reg      <= C'(s_axis_tdata[4*FW +: FW]);
            in_ih_reg      <= C'(s_axis_tdata[5*FW +: FW]);
        end
    end

    // fallback sizes, padding, padded box clamped to the image
    acw_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .pad_fraction (pad_fraction_reg),
        .in_valid     (in_v_reg),
        .in_ready     (prep_in_ready),
        .in_present   (in_present_reg),
        .in_bx        (in_bx_reg),
        .in_by        (in_by_reg),
        .in_bw        (in_bw_reg),
        .in_bh        (in_bh_reg),
        .in_iw        (in_iw_reg),
        .in_ih        (in_ih_reg),
        .out_valid    (prep_valid),
        .out_ready    (prep_ready),
        .out_geom     (prep_geom),
        .out_x0       (prep_x0),
        .out_y0       (prep_y0),
        .out_x1       (prep_x1),
        .out_y1       (prep_y1)
    );

    // widen to 16:9 and shrink to fit the image
    acw_fit #(
        .COORD_BITS (COORD_BITS)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_geom   (prep_geom),
        .in_x0     (prep_x0),
        .in_y0     (prep_y0),
        .in_x1     (prep_x1),
        .in_y1     (prep_y1),
        .out_valid (fit_valid),
        .out_ready (fit_ready),
        .out_geom  (fit_geom),
        .out_x0    (fit_x0),
        .out_y0    (fit_y0),
        .out_x1    (fit_x1),
        .out_y1    (fit_y1),
        .out_cw    (fit_cw),
        .out_ch    (fit_ch)
    );

    // centre, cover the padded box, clamp
    acw_place #(
        .COORD_BITS (COORD_BITS)
    ) u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fit_valid),
        .in_ready  (fit_ready),
        .in_geom   (fit_geom),
        .in_x0     (fit_x0),
        .in_y0     (fit_y0),
        .in_x1     (fit_x1),
        .in_y1     (fit_y1),
        .in_cw     (fit_cw),
        .in_ch     (fit_ch),
        .out_valid (place_valid),
        .out_ready (place_ready),
        .out_ok    (place_ok),
        .out_cx    (place_cx),
        .out_cy    (place_cy),
        .out_cw    (place_cw),
        .out_ch    (place_ch)
    );

    // output register parts the pipe from the receiver
    assign place_ready = !out_v_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (place_ready)
            out_v_reg <= place_valid;
    end

    always_ff @(posedge clk)
    begin
        if (place_valid && place_ready)
        begin
            out_ok_reg <= place_ok;
            out_cx_reg <= FW'(place_cx);
            out_cy_reg <= FW'(place_cy);
            out_cw_reg <= FW'(place_cw);
            out_ch_reg <= FW'(place_ch);
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {out_ch_reg, out_cw_reg, out_cy_reg, out_cx_reg};

`ifndef SYNTH
    // an empty input register must always take a beat
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_v_reg |-> s_axis_tready
    ) else $error("input register empty but s_axis_tready low");

    // a failed crop carries an all-zero window
    a_zero_when_not_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0
    ) else $error("crop_ok low with nonzero window");

    // a waiting result refills the output register as the current beat leaves
    a_output_refill: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && place_valid |=> m_axis_tvalid
    ) else $error("output register not refilled from waiting result");
`endif

endmodule
